// File: rtl/ubds_pkg.sv
// shared constants and types for the uart baud divisor search unit
// no dependencies
package ubds_pkg;

	// field widths
	localparam int unsigned BAUD_W      = 32;
	localparam int unsigned BUS_W       = 32;
	localparam int unsigned OVS_OUT_W   = 4;
	localparam int unsigned FRAC_OUT_W  = 8;
	localparam int unsigned DIV_OUT_W   = 16;

	// default search limits
	localparam int unsigned OVERSAMPLE_MAX_DEF = 15;
	localparam int unsigned FRACTION_MAX_DEF   = 255;
	localparam int unsigned DIVIDER_MAX_DEF    = 65535;

	// bus clock after reset
	localparam logic [BUS_W-1:0] BUS_CLOCK_RST = 32'd16000000;

	// rounding term that fills the 8 fraction bits of the scaled clock
	localparam int unsigned FRAC_SHIFT = 8;
	localparam logic [FRAC_SHIFT-1:0] ROUND_ADD = 8'd127;

	// oversample scan stops once it falls to this value
	localparam int unsigned OVS_LOW = 8;

	// shared divider: scaled clock dividend over a 32-bit divisor
	localparam int unsigned DVD_W = BUS_W + FRAC_SHIFT;
	localparam int unsigned DSR_W = BAUD_W;
	localparam int unsigned CNT_W = $clog2(DVD_W);

	// sequencer states
	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DIV   = 6'b000010,
		ST_CHECK = 6'b000100,
		ST_SCAN  = 6'b001000,
		ST_PDIV  = 6'b010000,
		ST_EVAL  = 6'b100000
	} ubds_state_t;

endpackage

// File: rtl/uart_baud_divisor_search_unit.sv
// uart baud divisor search unit: top level and only module
// depends on ubds_pkg for widths, defaults and the state type
//
// Start a search by raising start while busy is low; baud_rate is sampled on that edge.
// The result comes back as a single-cycle done strobe with status, oversample_value,
// fraction_value and divider_value; the receiver cannot stall it, so capture it on done.
// One shared restoring divider (one quotient bit per cycle) does all the work: first
// the 40-step division (bus_clock_hz*256+127)/baud_rate, then one division per
// candidate pair of oversample and fraction, each with TGT_W+1 divide steps, one setup
// and one compare, where TGT_W is the width of the largest legal target (29 bits with
// the default limits). Up to 8 x 255 pairs are tried; a zero error ends the scan early,
// and a zero baud rate or out-of-range target returns a failure status without a scan.
// bus_clock_hz is written through cfg_wr_en / cfg_wr_data; the user must write it only
// while busy is low, which the block itself leaves unenforced.
module uart_baud_divisor_search_unit #(
	parameter int unsigned OVERSAMPLE_MAX = ubds_pkg::OVERSAMPLE_MAX_DEF,
	parameter int unsigned FRACTION_MAX   = ubds_pkg::FRACTION_MAX_DEF,
	parameter int unsigned DIVIDER_MAX    = ubds_pkg::DIVIDER_MAX_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write
	input  logic                             cfg_wr_en,
	input  logic [ubds_pkg::BUS_W-1:0]       cfg_wr_data,
	// command
	input  logic                             start,
	output logic                             busy,
	input  logic [ubds_pkg::BAUD_W-1:0]      baud_rate,
	// result
	output logic                             done,
	output logic                             status,
	output logic [ubds_pkg::OVS_OUT_W-1:0]   oversample_value,
	output logic [ubds_pkg::FRAC_OUT_W-1:0]  fraction_value,
	output logic [ubds_pkg::DIV_OUT_W-1:0]   divider_value
);
	import ubds_pkg::*;

	// largest target that can still be reached
	localparam longint unsigned MAX_DIV = 64'(OVERSAMPLE_MAX + 1) * 64'(DIVIDER_MAX + 1) *
		64'(FRACTION_MAX + 256);
	localparam int unsigned TGT_W = $clog2(MAX_DIV + 1);
	// target plus half product
	localparam int unsigned SUM_W = TGT_W + 1;
	// product (oversample) * (256 + fraction)
	localparam int unsigned M_W   = $clog2((OVERSAMPLE_MAX + 1) * (FRACTION_MAX + 256) + 1);
	localparam int unsigned OVS_W = $clog2(OVERSAMPLE_MAX + 2);
	localparam int unsigned FP_W  = $clog2(FRACTION_MAX + 1);

	ubds_state_t state_q;

	logic [BUS_W-1:0]       bus_clock_hz_q;
	logic [TGT_W-1:0]       target_q;
	logic [OVS_W-1:0]       ovs_q;
	logic [FP_W-1:0]        fp_q;
	logic [M_W-1:0]         m_q;
	logic                   found_q;
	logic [M_W-1:0]         best_err_q;
	logic [OVS_OUT_W-1:0]   best_ovs_q;
	logic [FRAC_OUT_W-1:0]  best_frac_q;
	logic [DIV_OUT_W-1:0]   best_div_q;

	// shared divider registers
	logic [DSR_W-1:0]       rem_q;
	logic [DVD_W-1:0]       quo_q;
	logic [DSR_W-1:0]       dvsr_q;
	logic [CNT_W-1:0]       cnt_q;

	// result registers
	logic                   done_q;
	logic                   status_q;
	logic [OVS_OUT_W-1:0]   ovs_out_q;
	logic [FRAC_OUT_W-1:0]  frac_out_q;
	logic [DIV_OUT_W-1:0]   div_out_q;

	// divider step
	logic [DSR_W:0]         shl;
	logic [DSR_W+1:0]       diff;
	logic                   qbit;
	logic [DSR_W-1:0]       rem_nxt;
	logic [DVD_W-1:0]       quo_nxt;

	// candidate arithmetic
	logic [M_W-2:0]         half;
	logic [SUM_W-1:0]       sum;
	logic [M_W-1:0]         rem_m;
	logic [M_W-1:0]         err;
	logic [SUM_W-1:0]       dp1;
	logic                   dp1_ok;
	logic                   better;
	logic                   inner_go;
	logic                   exact;
	logic [OVS_W-1:0]       ovs_dec;

	always_comb begin
		shl     = {rem_q, quo_q[DVD_W-1]};
		diff    = {1'b0, shl} - {2'b0, dvsr_q};
		qbit    = ~diff[DSR_W+1];
		rem_nxt = qbit ? diff[DSR_W-1:0] : shl[DSR_W-1:0];
		quo_nxt = {quo_q[DVD_W-2:0], qbit};
	end

	always_comb begin
		half     = m_q[M_W-1:1];
		sum      = {1'b0, target_q} + SUM_W'(half);
		rem_m    = rem_q[M_W-1:0];
		// distance of the rounded remainder from the midpoint
		err      = (rem_m >= M_W'(half)) ? (rem_m - M_W'(half)) : (M_W'(half) - rem_m);
		dp1      = quo_q[SUM_W-1:0];
		dp1_ok   = dp1 <= SUM_W'(DIVIDER_MAX + 1);
		better   = !found_q || (err < best_err_q);
		exact    = found_q && (best_err_q == '0);
		inner_go = (fp_q < FP_W'(FRACTION_MAX)) && !exact &&
			(SUM_W'(half) <= SUM_W'(target_q));
		ovs_dec  = ovs_q - OVS_W'(1);
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_clock_hz_q <= BUS_CLOCK_RST;
		end else if (cfg_wr_en) begin
			bus_clock_hz_q <= cfg_wr_data;
		end
	end

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			done_q      <= 1'b0;
			status_q    <= 1'b0;
			ovs_out_q   <= '0;
			frac_out_q  <= '0;
			div_out_q   <= '0;
			found_q     <= 1'b0;
			best_err_q  <= '0;
			best_ovs_q  <= '0;
			best_frac_q <= '0;
			best_div_q  <= '0;
			target_q    <= '0;
			ovs_q       <= '0;
			fp_q        <= '0;
			m_q         <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			dvsr_q      <= '0;
			cnt_q       <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						found_q <= 1'b0;
						if (baud_rate == '0) begin
							// zero baud rate fails at once
							done_q     <= 1'b1;
							status_q   <= 1'b1;
							ovs_out_q  <= '0;
							frac_out_q <= '0;
							div_out_q  <= '0;
						end else begin
							// (bus * 256 + 127) / baud
							rem_q   <= '0;
							quo_q   <= {bus_clock_hz_q, ROUND_ADD};
							dvsr_q  <= baud_rate;
							cnt_q   <= CNT_W'(DVD_W - 1);
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					rem_q <= rem_nxt;
					quo_q <= quo_nxt;
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (quo_q > DVD_W'(MAX_DIV)) begin
						// target out of reach
						done_q     <= 1'b1;
						status_q   <= 1'b1;
						ovs_out_q  <= '0;
						frac_out_q <= '0;
						div_out_q  <= '0;
						state_q    <= ST_IDLE;
					end else begin
						target_q <= quo_q[TGT_W-1:0];
						ovs_q    <= OVS_W'(OVERSAMPLE_MAX + 1);
						fp_q     <= '0;
						m_q      <= M_W'((OVERSAMPLE_MAX + 1) * 256);
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (inner_go) begin
						// (target + m/2) divided by m
						rem_q   <= '0;
						quo_q   <= {sum, {(DVD_W - SUM_W){1'b0}}};
						dvsr_q  <= DSR_W'(m_q);
						cnt_q   <= CNT_W'(SUM_W - 1);
						state_q <= ST_PDIV;
					end else if (!exact && (ovs_dec > OVS_W'(OVS_LOW))) begin
						// next oversample, fraction restarts at zero
						ovs_q <= ovs_dec;
						fp_q  <= '0;
						m_q   <= M_W'({ovs_dec, 8'b0});
					end else begin
						done_q     <= 1'b1;
						status_q   <= !found_q;
						ovs_out_q  <= found_q ? best_ovs_q : '0;
						frac_out_q <= found_q ? best_frac_q : '0;
						div_out_q  <= found_q ? best_div_q : '0;
						state_q    <= ST_IDLE;
					end
				end
				ST_PDIV: begin
					rem_q <= rem_nxt;
					quo_q <= quo_nxt;
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					// first strictly smaller error with a divider in range wins
					if (better && dp1_ok) begin
						found_q     <= 1'b1;
						best_err_q  <= err;
						best_ovs_q  <= OVS_OUT_W'(ovs_dec);
						best_frac_q <= FRAC_OUT_W'(fp_q);
						best_div_q  <= dp1[DIV_OUT_W-1:0] - DIV_OUT_W'(1);
					end
					fp_q    <= fp_q + FP_W'(1);
					m_q     <= m_q + M_W'(ovs_q);
					state_q <= ST_SCAN;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy             = (state_q != ST_IDLE);
	assign done             = done_q;
	assign status           = status_q;
	assign oversample_value = ovs_out_q;
	assign fraction_value   = frac_out_q;
	assign divider_value    = div_out_q;

endmodule
